// File: design/dls_pkg.sv
package dls_pkg;

  localparam int DELIM_W     = 64;
  localparam int LEN_W       = 4;
  localparam int IDX_W       = 3;
  localparam int MAX_DELIM_D = 8;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIM_BYTES  = 1'b0,
    CFG_DELIM_LENGTH = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] data_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       line_end;
    logic       at_close;
    logic       last;
  } out_item_t;

  // one classified input: replay held prefix, then one final result
  typedef struct packed {
    logic [IDX_W-1:0] replay;
    logic [7:0]       fin_byte;
    logic             fin_valid;
    logic             fin_lend;
    logic             fin_close;
  } job_t;

  function automatic logic [7:0] delim_at(input logic [DELIM_W-1:0] bytes,
                                          input logic [IDX_W-1:0]   idx);
    delim_at = bytes[{idx, 3'b000} +: 8];
  endfunction

endpackage

// File: design/dls_if.sv
interface dls_in_if;
  logic               valid;
  logic               ready;
  dls_pkg::in_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface dls_out_if;
  logic               valid;
  logic               ready;
  dls_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// File: design/delimiter_line_splitter.sv
// A result beat passes from the job queue into the output register before it leaves.
// Throughput: one input beat per cycle while the job queue is not full; an input that replays n held
//   delimiter bytes yields n+1 result beats, all through the single output register.
// A 2-entry job queue between classifier and emitter absorbs replay bursts.
// Reset (rst_n low, synchronous): match count, pending flag, queue and output
//   valid cleared; delimiter registers return to zero (passthrough).
module delimiter_line_splitter #(
  parameter int MAX_DELIM = dls_pkg::MAX_DELIM_D
) (
  input  logic                             clk,
  input  logic                             rst_n,
  dls_in_if.sink                           in_if,
  dls_out_if.source                        out_if,
  input  logic                             cfg_we,
  input  logic [dls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dls_pkg::DELIM_W-1:0]      cfg_data
);

  logic [dls_pkg::DELIM_W-1:0] delim_bytes_r;
  logic [dls_pkg::LEN_W-1:0]   delim_len_r;
  logic                        push, pop, q_full, q_empty;
  dls_pkg::job_t               push_job, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_bytes_r <= '0;
      delim_len_r   <= '0;
    end else if (cfg_we) begin
      unique case (dls_pkg::cfg_idx_t'(cfg_index))
        dls_pkg::CFG_DELIM_BYTES:  delim_bytes_r <= cfg_data;
        dls_pkg::CFG_DELIM_LENGTH: delim_len_r   <= cfg_data[dls_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  dls_front #(.MAX_DELIM(MAX_DELIM)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .delim_bytes (delim_bytes_r),
    .delim_len   (delim_len_r),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  dls_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  dls_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .delim_bytes (delim_bytes_r),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .out_if      (out_if)
  );

endmodule

// File: design/dls_front.sv
module dls_front #(
  parameter int MAX_DELIM = dls_pkg::MAX_DELIM_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dls_in_if.sink                        in_if,
  input  logic [dls_pkg::DELIM_W-1:0]   delim_bytes,
  input  logic [dls_pkg::LEN_W-1:0]     delim_len,
  input  logic                          q_full,
  output logic                          push,
  output dls_pkg::job_t                 push_job
);

  localparam int CNT_W = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;

  logic [CNT_W-1:0]           mc_r, mc_nxt;
  logic                       pend_r, pend_nxt;
  logic [dls_pkg::LEN_W-1:0]  len_used;
  logic                       accept;
  logic [7:0]                 exp_byte;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;
  assign len_used    = (delim_len > dls_pkg::LEN_W'(MAX_DELIM))
                       ? dls_pkg::LEN_W'(MAX_DELIM) : delim_len;
  assign exp_byte    = dls_pkg::delim_at(delim_bytes, dls_pkg::IDX_W'(mc_r));

  always_comb begin
    push     = 1'b0;
    push_job = '0;
    mc_nxt   = mc_r;
    pend_nxt = pend_r;
    if (accept) begin
      if (in_if.item.opcode == dls_pkg::OP_FLUSH) begin
        if (pend_r || (mc_r != '0)) begin
          push               = 1'b1;
          push_job.replay    = dls_pkg::IDX_W'(mc_r);
          push_job.fin_lend  = 1'b1;
          push_job.fin_close = 1'b1;
        end
        mc_nxt   = '0;
        pend_nxt = 1'b0;
      end else if (len_used == '0) begin
        push               = 1'b1;
        push_job.replay    = dls_pkg::IDX_W'(mc_r);
        push_job.fin_byte  = in_if.item.data_byte;
        push_job.fin_valid = 1'b1;
        push_job.fin_lend  = in_if.item.chunk_end;
        mc_nxt             = '0;
        pend_nxt           = !in_if.item.chunk_end;
      end else if (in_if.item.data_byte == exp_byte) begin
        if ((dls_pkg::LEN_W'(mc_r) + dls_pkg::LEN_W'(1)) >= len_used) begin
          push              = 1'b1;
          push_job.fin_lend = 1'b1;
          mc_nxt            = '0;
          pend_nxt          = 1'b0;
        end else begin
          mc_nxt = mc_r + CNT_W'(1);
        end
      end else begin
        push               = 1'b1;
        push_job.replay    = dls_pkg::IDX_W'(mc_r);
        push_job.fin_byte  = in_if.item.data_byte;
        push_job.fin_valid = 1'b1;
        mc_nxt             = '0;
        pend_nxt           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r   <= '0;
      pend_r <= 1'b0;
    end else begin
      mc_r   <= mc_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

// File: design/dls_queue.sv
module dls_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dls_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output dls_pkg::job_t head
);

  dls_pkg::job_t slot_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// File: design/dls_back.sv
module dls_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [dls_pkg::DELIM_W-1:0]  delim_bytes,
  input  logic                         q_empty,
  input  dls_pkg::job_t                head,
  output logic                         pop,
  dls_out_if.source                    out_if
);

  logic [dls_pkg::IDX_W-1:0] k_r, k_nxt;
  logic                      ov_r, ov_nxt;
  dls_pkg::out_item_t        oi_r, oi_nxt;
  logic                      can_load;

  assign can_load     = !ov_r || out_if.ready;
  assign out_if.valid = ov_r;
  assign out_if.item  = oi_r;

  always_comb begin
    pop    = 1'b0;
    k_nxt  = k_r;
    oi_nxt = oi_r;
    ov_nxt = ov_r && !out_if.ready;
    if (!q_empty && can_load) begin
      ov_nxt = 1'b1;
      if (k_r != head.replay) begin
        oi_nxt.out_byte   = dls_pkg::delim_at(delim_bytes, k_r);
        oi_nxt.byte_valid = 1'b1;
        oi_nxt.line_end   = 1'b0;
        oi_nxt.at_close   = 1'b0;
        oi_nxt.last       = 1'b0;
        k_nxt             = k_r + dls_pkg::IDX_W'(1);
      end else begin
        oi_nxt.out_byte   = head.fin_byte;
        oi_nxt.byte_valid = head.fin_valid;
        oi_nxt.line_end   = head.fin_lend;
        oi_nxt.at_close   = head.fin_close;
        oi_nxt.last       = 1'b1;
        k_nxt             = '0;
        pop               = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    oi_r <= oi_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      k_r  <= k_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule

// File: design/dls_checker.sv
module dls_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input dls_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_close_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.at_close |->
      out_item.line_end && !out_item.byte_valid && out_item.last)
    else $error("close marker malformed");

  a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.byte_valid |->
      out_item.line_end && out_item.last && (out_item.out_byte == 8'd0))
    else $error("line end marker malformed");

endmodule

bind delimiter_line_splitter dls_checker u_dls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_item  (out_if.item)
);
